@@ sv/fpms_pkg.sv @@
// Shared types and constants for the falling path minimum sum core.
// Depends on nothing; fpms_front, fpms_back, the top level and the testbench import it.
package fpms_pkg;

    localparam int CELL_W      = 16;
    localparam int SUM_W       = 22;
    localparam int SIZE_W      = 7;
    localparam int OUT_TDATA_W = 24;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

    typedef logic signed [CELL_W-1:0] cell_t;
    typedef logic signed [SUM_W-1:0]  sum_t;

    localparam sum_t SUM_MAX = 22'sh1FFFFF;
    localparam sum_t SUM_MIN = 22'sh200000;

    // Per-cell classification made by the front end
    typedef struct packed {
        logic first_row;
        logic last_row;
        logic col_zero;
        logic last_col;
        logic has_right;
        logic read_next;
    } fpms_flags_t;

endpackage

@@ sv/fpms_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module fpms_ram #(
    parameter int WIDTH = 22,
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ sv/fpms_queue.sv @@
// Two-entry queue between the front end and the back end.
// Depends on nothing.
module fpms_queue #(
    parameter int W = 28
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [W-1:0] in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [W-1:0] out_data
);

    logic [W-1:0] slot_reg [2];
    logic         wr_ptr_reg, wr_ptr_next;
    logic         rd_ptr_reg, rd_ptr_next;
    logic [1:0]   count_reg, count_next;
    logic         push, pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");
    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 2'd1))
        else $error("push without pop did not grow the queue");
`endif

endmodule

@@ sv/fpms_front.sv @@
// Front end: holds the size register, tracks row and column, classifies cells.
// Depends on fpms_pkg.
module fpms_front #(
    parameter int MAX_SIZE = 64,
    parameter int CW       = 6
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [fpms_pkg::SIZE_W-1:0] cfg_wdata,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  fpms_pkg::cell_t             in_cell,
    output logic                        push_valid,
    input  logic                        push_ready,
    output fpms_pkg::fpms_flags_t       push_flags,
    output fpms_pkg::cell_t             push_cell,
    output logic [CW-1:0]               push_col
);

    import fpms_pkg::*;

    logic [SIZE_W-1:0] size_reg;
    logic [CW-1:0]     col_reg, col_next;
    logic [CW-1:0]     row_reg, row_next;
    logic [CW-1:0]     n_last;
    logic [CW-1:0]     col_inc;
    logic              accept;

    // Clamp the size to 1..MAX_SIZE and keep n-1
    always_comb
    begin
        if (size_reg == '0)
        begin
            n_last = '0;
        end
        else if (32'(size_reg) > 32'(MAX_SIZE))
        begin
            n_last = CW'(MAX_SIZE - 1);
        end
        else
        begin
            n_last = CW'(32'(size_reg) - 32'd1);
        end
    end

    assign in_ready   = push_ready;
    assign push_valid = in_valid;
    assign push_cell  = in_cell;
    assign push_col   = col_reg;
    assign accept     = in_valid && push_ready;
    assign col_inc    = col_reg + CW'(1);

    always_comb
    begin
        push_flags.first_row = (row_reg == '0);
        push_flags.last_row  = (row_reg == n_last);
        push_flags.col_zero  = (col_reg == '0);
        push_flags.last_col  = (col_reg == n_last);
        push_flags.has_right = (col_reg != n_last);
        // Fetch the right neighbor for the following cell
        push_flags.read_next = (col_reg == n_last) ? (n_last != '0) : (col_inc != n_last);
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (col_reg == n_last)
            begin
                col_next = '0;
                row_next = (row_reg == n_last) ? '0 : row_reg + CW'(1);
            end
            else
            begin
                col_next = col_inc;
            end
        end
        if (cfg_we)
        begin
            col_next = '0;
            row_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= SIZE_RESET;
            col_reg  <= '0;
            row_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                size_reg <= cfg_wdata;
            end
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

`ifndef ASSERT_OFF
    a_matrix_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && push_flags.last_row && push_flags.last_col)
        |=> (row_reg == '0 && col_reg == '0))
        else $error("front end did not restart after the final cell");
`endif

endmodule

@@ sv/fpms_back.sv @@
// Back end: neighbor window, row store, path sum, running minimum, result register.
// Depends on fpms_pkg and fpms_ram.
module fpms_back #(
    parameter int MAX_SIZE = 64,
    parameter int CW       = 6
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  restart,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  fpms_pkg::fpms_flags_t in_flags,
    input  fpms_pkg::cell_t       in_cell,
    input  logic [CW-1:0]         in_col,
    output logic                  m_valid,
    input  logic                  m_ready,
    output fpms_pkg::sum_t        m_sum
);

    import fpms_pkg::*;

    logic              pop;
    logic [CW-1:0]     raddr;
    logic [SUM_W-1:0]  rd_data;
    logic              fwd_valid_reg;
    sum_t              fwd_val_reg;
    sum_t              left_reg;
    sum_t              ctr_reg;
    sum_t              start_reg;
    sum_t              run_min_reg;
    sum_t              out_reg;
    logic              out_valid_reg;
    sum_t              right_val;
    sum_t              center;
    sum_t              best;
    logic signed [SUM_W:0] wide;
    sum_t              sum;
    sum_t              cand;

    assign in_ready = !out_valid_reg || m_ready;
    assign pop      = in_valid && in_ready;
    assign raddr    = in_flags.last_col ? CW'(1) : in_col + CW'(2);
    assign m_valid  = out_valid_reg;
    assign m_sum    = out_reg;

    fpms_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_SIZE),
        .AW    (CW)
    ) u_row_store (
        .clk   (clk),
        .we    (pop),
        .waddr (in_col),
        .wdata (sum),
        .re    (pop && in_flags.read_next),
        .raddr (raddr),
        .rdata (rd_data)
    );

    always_comb
    begin
        right_val = fwd_valid_reg ? fwd_val_reg : sum_t'(rd_data);
        center    = in_flags.col_zero ? start_reg : ctr_reg;
        best      = center;
        if (!in_flags.col_zero && left_reg < best)
        begin
            best = left_reg;
        end
        if (in_flags.has_right && right_val < best)
        begin
            best = right_val;
        end
        wide = {{(SUM_W + 1 - CELL_W){in_cell[CELL_W-1]}}, in_cell} + {best[SUM_W-1], best};
        if (in_flags.first_row)
        begin
            sum = {{(SUM_W - CELL_W){in_cell[CELL_W-1]}}, in_cell};
        end
        else if (wide[SUM_W] != wide[SUM_W-1])
        begin
            sum = wide[SUM_W] ? SUM_MIN : SUM_MAX;
        end
        else
        begin
            sum = wide[SUM_W-1:0];
        end
        cand = (sum < run_min_reg) ? sum : run_min_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_valid_reg <= 1'b0;
            run_min_reg   <= SUM_MAX;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && m_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (pop && in_flags.read_next)
            begin
                fwd_valid_reg <= (raddr == in_col);
            end
            if (pop && in_flags.last_row)
            begin
                if (in_flags.last_col)
                begin
                    out_valid_reg <= 1'b1;
                    run_min_reg   <= SUM_MAX;
                end
                else
                begin
                    run_min_reg <= cand;
                end
            end
            if (restart)
            begin
                run_min_reg <= SUM_MAX;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            left_reg <= center;
            ctr_reg  <= right_val;
            if (in_flags.col_zero)
            begin
                start_reg <= sum;
            end
            if (in_flags.read_next)
            begin
                fwd_val_reg <= sum;
            end
            if (in_flags.last_row && in_flags.last_col)
            begin
                out_reg <= cand;
            end
        end
    end

`ifndef ASSERT_OFF
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(pop && in_flags.last_row && in_flags.last_col))
        else $error("result raised without a final cell");
    a_final_makes_result: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && in_flags.last_row && in_flags.last_col) |=> out_valid_reg)
        else $error("final cell did not produce a result");
    a_min_restart: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> (run_min_reg == SUM_MAX))
        else $error("running minimum not restarted after a result");
`endif

endmodule

@@ sv/falling_path_min_sum_core.sv @@
// Top level of the falling path minimum sum core: front end, queue, back end.
// Depends on fpms_pkg, fpms_front, fpms_queue and fpms_back.
//
// Usage:
//   Stream the cells of an n x n signed matrix in row-major order on the
//   s_* channel, one cell per item. After the last cell of the last row the
//   core delivers one item on the m_* channel: the minimum falling path sum,
//   where each cell adds the smallest of its up to three neighbors above.
//   Write cfg_wdata with cfg_we to set n (0 acts as 1, values above
//   MAX_SIZE act as MAX_SIZE); a write restarts the matrix at row 0, column 0
//   and must only happen while the core is idle.
//   Throughput: one cell per cycle while no result waits on m_tready, set
//   by the single read port of the row store, which fetches one upper-right neighbor per cell.
//   Result path: the final cell is held in the queue until the back end
//   pops it, and the back end then registers the result and raises
//   m_tvalid.
//   Reset: n returns to 64, position returns to row 0, column 0; the row
//   store is not cleared since the first row of every matrix rewrites it.
//   Stall: while a result waits on m_tready, the back end holds; the two-entry
//   queue absorbs the cells in flight and then s_tready drops.
module falling_path_min_sum_core #(
    parameter int MAX_SIZE = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [fpms_pkg::SIZE_W-1:0]      cfg_wdata,  // matrix_size
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [fpms_pkg::CELL_W-1:0]      s_tdata,    // [15:0] cell_value
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [fpms_pkg::OUT_TDATA_W-1:0] m_tdata     // [21:0] min_sum, [23:22] zero
);

    import fpms_pkg::*;

    // Column index width; also the row store address width
    localparam int CW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int FW = $bits(fpms_flags_t);
    localparam int QW = FW + CELL_W + CW;

    fpms_flags_t      push_flags, pop_flags;
    cell_t            push_cell, pop_cell;
    logic [CW-1:0]    push_col, pop_col;
    logic             push_valid, push_ready;
    logic             pop_valid, pop_ready;
    logic [QW-1:0]    push_data, pop_data;
    sum_t             result;

    // Classify each cell by its place in the matrix
    fpms_front #(
        .MAX_SIZE (MAX_SIZE),
        .CW       (CW)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_cell    (cell_t'(s_tdata)),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_flags (push_flags),
        .push_cell  (push_cell),
        .push_col   (push_col)
    );

    assign push_data = {push_flags, push_cell, push_col};
    assign {pop_flags, pop_cell, pop_col} = pop_data;

    // Decouple the two sides so a stalled result does not stop input at once
    fpms_queue #(
        .W (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_data   (push_data),
        .out_valid (pop_valid),
        .out_ready (pop_ready),
        .out_data  (pop_data)
    );

    // Compute path sums against the previous row and hold the result
    fpms_back #(
        .MAX_SIZE (MAX_SIZE),
        .CW       (CW)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .restart  (cfg_we),
        .in_valid (pop_valid),
        .in_ready (pop_ready),
        .in_flags (pop_flags),
        .in_cell  (pop_cell),
        .in_col   (pop_col),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_sum    (result)
    );

    // Zero-fill the result to whole bytes
    assign m_tdata = {{(OUT_TDATA_W - SUM_W){1'b0}}, result};

endmodule

@@ dv/tb_falling_path_min_sum_core.sv @@
// Self-checking testbench for falling_path_min_sum_core: streams signed matrices
// cell by cell, predicts each minimum falling path sum and checks every result item.
// Depends on fpms_pkg and the falling_path_min_sum_core RTL.
module tb_falling_path_min_sum_core;

    timeunit 1ns;
    timeprecision 1ps;

    import fpms_pkg::*;

    localparam int MAX_N = 64;

    // Styles of cell content for a run of pushed cells
    typedef enum int
    {
        CELLS_ANY,
        CELLS_EXTREME,
        CELLS_NEAR_ZERO,
        CELLS_ALL_MIN
    } cell_style_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [SIZE_W-1:0]      cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [CELL_W-1:0]      s_tdata   = '0;   // [15:0] cell_value
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;          // [21:0] min_sum, [23:22] zero

    // Cells waiting for the driver, and minimum sums waiting for the monitor
    cell_t cell_q[$];
    sum_t  min_sum_q[$];

    int cells_pushed   = 0;
    int cells_taken    = 0;
    int mismatch_count = 0;

    // Idle behavior of each side, switched per phase by the stimulus
    bit send_idle_on = 1'b0;
    bit recv_idle_on = 1'b0;
    int send_wait    = 0;
    int recv_wait    = 0;

    // Predictor state: mirrors the size register and the position in the matrix
    logic [SIZE_W-1:0] size_reg = SIZE_RESET;
    sum_t              path_row [MAX_N];
    sum_t              left_sum = '0;
    int unsigned       col_idx  = 0;
    int unsigned       row_idx  = 0;
    sum_t              row_min  = SUM_MAX;
    sum_t              want_sum;

    falling_path_min_sum_core #(
        .MAX_SIZE (MAX_N)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 clk = ~clk;

    // Return to row 0, column 0 with an empty running minimum
    function automatic void start_matrix();
        left_sum = '0;
        col_idx  = 0;
        row_idx  = 0;
        row_min  = SUM_MAX;
    endfunction

    // Fold one accepted cell into the row of best sums; queue the minimum over
    // the last row once the final cell of the matrix has gone in.
    function automatic void advance_path_sums(cell_t cell_in);
        int unsigned n;
        int unsigned j;
        int          best;
        int          total;
        sum_t        path;
        // Size 0 behaves as 1, anything above the row buffer as its depth
        n = (size_reg == 0) ? 1 : (size_reg > MAX_N) ? MAX_N : size_reg;
        j = (col_idx >= n) ? n - 1 : col_idx;
        best = 0;
        if (row_idx != 0)
        begin
            // Above, above-left (saved before it was overwritten), above-right
            best = path_row[j];
            if (j > 0 && left_sum < best)
                best = left_sum;
            if (j + 1 < n && path_row[j + 1] < best)
                best = path_row[j + 1];
        end
        total = int'(cell_in) + best;
        // Saturate the path sum to the 22-bit range
        if (total > int'(SUM_MAX))
            path = SUM_MAX;
        else if (total < int'(SUM_MIN))
            path = SUM_MIN;
        else
            path = sum_t'(total);
        left_sum    = path_row[j];
        path_row[j] = path;
        if (row_idx + 1 >= n && path < row_min)
            row_min = path;
        if (j + 1 >= n)
        begin
            col_idx  = 0;
            left_sum = '0;
            if (row_idx + 1 >= n)
            begin
                min_sum_q.push_back(row_min);
                start_matrix();
            end
            else
                row_idx++;
        end
        else
            col_idx = j + 1;
    endfunction

    function automatic int draw_gap(bit idle_on);
        return idle_on ? int'($urandom_range(0, 18)) : 0;
    endfunction

    // Driver: present queued cells, hold while stalled, idle between items.
    // Predict on every accepted item and track size register writes.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid  <= 1'b0;
            s_tdata   <= '0;
            send_wait <= 0;
            size_reg  = SIZE_RESET;
            start_matrix();
            for (int i = 0; i < MAX_N; i++)
                path_row[i] = '0;
        end
        else
        begin
            // A write lands at this edge; it abandons any matrix in progress
            if (cfg_we)
            begin
                size_reg = cfg_wdata;
                start_matrix();
            end
            if (s_tvalid && s_tready)
            begin
                advance_path_sums(cell_t'(s_tdata));
                cells_taken++;
            end
            if (s_tvalid && !s_tready)
                ;   // hold the item until the core takes it
            else if (send_wait > 0)
            begin
                s_tvalid  <= 1'b0;
                send_wait <= send_wait - 1;
            end
            else if (cell_q.size() > 0)
            begin
                s_tvalid  <= 1'b1;
                s_tdata   <= cell_q.pop_front();
                send_wait <= draw_gap(send_idle_on);
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Monitor: compare each result item with the oldest predicted minimum.
    // When recv_idle_on is set, drop ready after a result and now and then at random.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            recv_wait <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (min_sum_q.size() == 0)
                begin
                    $display("%0t ns: unexpected result, expected none, actual %0d (0x%06h)",
                             $time, $signed(m_tdata[SUM_W-1:0]), m_tdata);
                    mismatch_count++;
                end
                else
                begin
                    want_sum = min_sum_q.pop_front();
                    if (m_tdata !== {{(OUT_TDATA_W - SUM_W){1'b0}}, want_sum})
                    begin
                        $display("%0t ns: min_sum expected %0d (0x%06h), actual %0d (0x%06h)",
                                 $time, want_sum, {{(OUT_TDATA_W - SUM_W){1'b0}}, want_sum},
                                 $signed(m_tdata[SUM_W-1:0]), m_tdata);
                        mismatch_count++;
                    end
                end
            end
            if (recv_wait > 0)
            begin
                m_tready  <= 1'b0;
                recv_wait <= recv_wait - 1;
            end
            else if (recv_idle_on && ((m_tvalid && m_tready) || $urandom_range(0, 7) == 0))
            begin
                m_tready  <= 1'b0;
                recv_wait <= $urandom_range(0, 18);
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Block until every pushed cell is taken and every result has come,
    // then let the queue and the back end empty.
    task automatic wait_drain();
        while (cells_taken != cells_pushed || min_sum_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write matrix_size only while the core is idle
    task automatic write_size(logic [SIZE_W-1:0] value);
        wait_drain();
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic push_cell(cell_t value);
        cell_q.push_back(value);
        cells_pushed++;
    endtask

    // Push a run of cells; with pause_at > 0, stop after that many cells and let
    // the core empty out before going on with the same matrix.
    task automatic push_cells(int count, cell_style_t style, int pause_at);
        cell_t value;
        for (int i = 1; i <= count; i++)
        begin
            case (style)
                CELLS_EXTREME:
                    case ($urandom_range(0, 3))
                        0: value = 16'sh7FFF;
                        1: value = 16'sh8000;
                        2: value = 16'sh0000;
                        default: value = 16'shFFFF;
                    endcase
                CELLS_NEAR_ZERO: value = cell_t'(int'($urandom_range(0, 40)) - 20);
                CELLS_ALL_MIN:   value = 16'sh8000;
                default:         value = cell_t'($urandom);
            endcase
            push_cell(value);
            if (i == pause_at)
                wait_drain();
        end
    endtask

    // Stimulus: directed matrices first, then random phases of random sizes
    initial
    begin
        int rand_goal;
        int raw;
        int n;
        int pick;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset size is 64: start a matrix and abandon it with the next write
        push_cell(16'sh7FFF);
        push_cell(16'sh8000);
        push_cell(16'shFFFF);

        // Size one: every cell is its own result
        write_size(7'd1);
        push_cell(16'sh7FFF);
        push_cell(16'sh8000);
        push_cell(16'sh0000);
        push_cell(16'sh0001);
        push_cell(16'shFFFF);

        // Size zero behaves as size one
        write_size(7'd0);
        push_cell(16'sh5555);

        // 3x3 with extremes: edge columns have only two neighbors above
        write_size(7'd3);
        push_cell(16'sh8000);
        push_cell(16'sh7FFF);
        push_cell(16'sh8000);
        push_cell(16'sh7FFF);
        push_cell(16'sh8000);
        push_cell(16'sh7FFF);
        push_cell(16'shFFFF);
        push_cell(16'sh0000);
        push_cell(16'sh0001);

        write_size(7'd2);
        push_cell(16'sh0005);
        push_cell(16'shFFF9);
        push_cell(16'sh0003);
        push_cell(16'shFFFE);

        // Oversized setting acts as 64: run past the first row of an all-minimum
        // matrix, pausing at the row boundary until the core is empty; the next
        // write abandons it.
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;
        write_size(7'd100);
        push_cells(MAX_N + 40, CELLS_ALL_MIN, MAX_N);

        // All-ones setting, then a partial matrix that the next write abandons
        write_size(7'd127);
        push_cells(70, CELLS_ANY, 0);

        // Random phases: mostly small matrices, some mid-sized, a few size zero
        rand_goal = cells_pushed + 1250;
        while (cells_pushed < rand_goal)
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                raw = 0;
            else if (pick < 14)
                raw = $urandom_range(1, 6);
            else
                raw = $urandom_range(7, 12);
            n = (raw == 0) ? 1 : raw;
            write_size(raw[SIZE_W-1:0]);
            send_idle_on = $urandom_range(0, 3) != 0;
            recv_idle_on = $urandom_range(0, 3) != 0;
            repeat ($urandom_range(1, 4))
                push_cells(n * n, cell_style_t'($urandom_range(0, 2)),
                           ($urandom_range(0, 5) == 0) ? int'($urandom_range(1, n * n)) : 0);
            // Leave a matrix unfinished now and then
            if (n > 1 && $urandom_range(0, 3) == 0)
                push_cells($urandom_range(1, n * n - 1), cell_style_t'($urandom_range(0, 2)), 0);
        end

        wait_drain();
        repeat (6) @(posedge clk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
